// ===== hw/rtl/frm_pkg.sv =====
// ----------------------------------------------------------------------------
// frm_pkg
// Shared types and constants for the frame rate meter: controller states,
// controller to datapath command and status groups, register indexes.
// ----------------------------------------------------------------------------
package frm_pkg;

	// configuration port
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_AVG_WINDOW  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RATE_WINDOW = 1'b1;

	localparam logic [CFG_DATA_W-1:0] AVG_WINDOW_RST  = 16'd20;
	localparam logic [CFG_DATA_W-1:0] RATE_WINDOW_RST = 16'd1000;

	// payload widths fixed by the port list
	localparam int unsigned FIELD_W = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_CHECK,
		ST_DIV_AVG,
		ST_DIV_RATE,
		ST_DONE
	} frm_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic update;
		logic div_start;
		logic div_rate;
		logic write_avg;
		logic write_rate;
		logic finish;
	} frm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic short_fire;
		logic long_fire;
		logic div_done;
	} frm_sts_t;

endpackage

// ===== hw/rtl/frm_div.sv =====
// ----------------------------------------------------------------------------
// frm_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle. A start
// loads the operands; done pulses for one cycle with the quotient held.
// ----------------------------------------------------------------------------
module frm_div #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [TIME_WIDTH-1:0] dividend,
	input  logic [TIME_WIDTH-1:0] divisor,
	output logic                  done,
	output logic [TIME_WIDTH-1:0] quotient
);
	localparam int unsigned CW = $clog2(TIME_WIDTH);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [TIME_WIDTH-1:0] rem_q;
	logic [TIME_WIDTH-1:0] dvd_q;
	logic [TIME_WIDTH-1:0] dsr_q;

	logic [TIME_WIDTH:0]   shifted;
	logic [TIME_WIDTH:0]   diff;
	logic                  fits;

	// one trial subtraction per cycle
	assign shifted = {rem_q, dvd_q[TIME_WIDTH-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(TIME_WIDTH - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TIME_WIDTH-1:0] : shifted[TIME_WIDTH-1:0];
			dvd_q <= {dvd_q[TIME_WIDTH-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== hw/rtl/frm_dp.sv =====
// ----------------------------------------------------------------------------
// frm_dp
// Datapath: window thresholds, tick state, window counts and sums, the
// shared divider and the output register.
// ----------------------------------------------------------------------------
module frm_dp #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [frm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [frm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [frm_pkg::FIELD_W-1:0]     timestamp_ms,
	input  frm_pkg::frm_cmd_t               cmd,
	output frm_pkg::frm_sts_t               sts,
	output logic [frm_pkg::FIELD_W-1:0]     delta_ms,
	output logic [frm_pkg::FIELD_W-1:0]     avg_frame_ms,
	output logic [frm_pkg::FIELD_W-1:0]     frames_per_second,
	output logic [frm_pkg::FIELD_W-1:0]     elapsed_ms,
	output logic [frm_pkg::FIELD_W-1:0]     tick_number
);
	import frm_pkg::*;

	localparam int unsigned W = TIME_WIDTH;

	logic [CFG_DATA_W-1:0] avg_win_q;
	logic [CFG_DATA_W-1:0] rate_win_q;

	logic [W-1:0] now_q;
	logic [W-1:0] prev_q;
	logic [W-1:0] delta_q;
	logic [W-1:0] tick_q;
	logic [W-1:0] scount_q;
	logic [W-1:0] ssum_q;
	logic [W-1:0] lcount_q;
	logic [W-1:0] lsum_q;
	logic [W-1:0] avg_q;
	logic [W-1:0] rate_q;
	logic [W-1:0] elap_q;

	logic [W-1:0] delta;
	logic [W-1:0] elap_next;
	logic [W-1:0] frames_ms;
	logic [W-1:0] div_dividend;
	logic [W-1:0] div_divisor;
	logic [W-1:0] div_quot;
	logic         div_done;

	logic [FIELD_W-1:0] delta_out_q;
	logic [FIELD_W-1:0] avg_out_q;
	logic [FIELD_W-1:0] rate_out_q;
	logic [FIELD_W-1:0] elap_out_q;
	logic [FIELD_W-1:0] tick_out_q;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_win_q  <= AVG_WINDOW_RST;
			rate_win_q <= RATE_WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_AVG_WINDOW:  avg_win_q  <= cfg_data;
				CFG_RATE_WINDOW: rate_win_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			now_q <= W'(timestamp_ms);
		end
	end

	// wrapping interval since the previous beat
	assign delta = now_q - prev_q;

	// count * 1000 as 1024 - 16 - 8 shifted copies
	assign frames_ms = (lcount_q << 10) - (lcount_q << 4) - (lcount_q << 3);

	assign elap_next = elap_q + avg_q;

	// tick and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			delta_q  <= '0;
			tick_q   <= '0;
			scount_q <= '0;
			ssum_q   <= '0;
			lcount_q <= '0;
			lsum_q   <= '0;
			avg_q    <= '0;
			rate_q   <= '0;
			elap_q   <= '0;
		end else begin
			if (cmd.update) begin
				prev_q   <= now_q;
				delta_q  <= delta;
				tick_q   <= tick_q + 1'b1;
				scount_q <= scount_q + 1'b1;
				ssum_q   <= ssum_q + delta;
				lcount_q <= lcount_q + 1'b1;
				lsum_q   <= lsum_q + delta;
			end
			if (cmd.write_avg) begin
				avg_q    <= div_quot;
				scount_q <= '0;
				ssum_q   <= '0;
			end
			if (cmd.write_rate) begin
				rate_q   <= div_quot;
				lcount_q <= '0;
				lsum_q   <= '0;
			end
			if (cmd.finish) begin
				elap_q <= elap_next;
			end
		end
	end

	// divider operand select
	assign div_dividend = cmd.div_rate ? frames_ms : ssum_q;
	assign div_divisor  = cmd.div_rate ? lsum_q    : scount_q;

	frm_div #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// window triggers
	assign sts.short_fire = ssum_q > W'(avg_win_q);
	assign sts.long_fire  = lsum_q > W'(rate_win_q);
	assign sts.div_done   = div_done;

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			delta_out_q <= FIELD_W'(delta_q);
			avg_out_q   <= FIELD_W'(avg_q);
			rate_out_q  <= FIELD_W'(rate_q);
			elap_out_q  <= FIELD_W'(elap_next);
			tick_out_q  <= FIELD_W'(tick_q);
		end
	end

	assign delta_ms          = delta_out_q;
	assign avg_frame_ms      = avg_out_q;
	assign frames_per_second = rate_out_q;
	assign elapsed_ms        = elap_out_q;
	assign tick_number       = tick_out_q;

endmodule

// ===== hw/rtl/frm_ctrl.sv =====
// ----------------------------------------------------------------------------
// frm_ctrl
// Controller: sequences one beat through update, window checks and the
// shared divider, and owns the input ready and output valid.
// ----------------------------------------------------------------------------
module frm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  frm_pkg::frm_sts_t sts,
	output frm_pkg::frm_cmd_t cmd
);
	import frm_pkg::*;

	frm_state_t state_q;
	frm_state_t state_next;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_next  = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.update = 1'b1;
				state_next = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.short_fire) begin
					cmd.div_start = 1'b1;
					state_next    = ST_DIV_AVG;
				end else if (sts.long_fire) begin
					cmd.div_start = 1'b1;
					cmd.div_rate  = 1'b1;
					state_next    = ST_DIV_RATE;
				end else begin
					state_next = ST_DONE;
				end
			end
			ST_DIV_AVG: begin
				if (sts.div_done) begin
					cmd.write_avg = 1'b1;
					if (sts.long_fire) begin
						cmd.div_start = 1'b1;
						cmd.div_rate  = 1'b1;
						state_next    = ST_DIV_RATE;
					end else begin
						state_next = ST_DONE;
					end
				end
			end
			ST_DIV_RATE: begin
				cmd.div_rate = 1'b1;
				if (sts.div_done) begin
					cmd.write_rate = 1'b1;
					state_next     = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/frame_rate_meter_top.sv =====
// ----------------------------------------------------------------------------
// frame_rate_meter_top
// Frame timing statistics from one millisecond timestamp per frame: wrapped
// delta, short window average frame time, long window frame rate, elapsed
// time and tick count.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    timestamp_ms
//   out      out_valid / out_ready  delta_ms, avg_frame_ms, frames_per_second,
//                                   elapsed_ms, tick_number
//   cfg      cfg_we                 cfg_index, cfg_data (write only)
//
// One beat at a time; each window that fires adds a division on the shared
// radix-2 divider.
// Reset clears control and window state; thresholds return to 20 and 1000 ms.
// A finished result waits in the output register; the next beat is taken
// meanwhile and stalls only at its own end if the result is still pending.
// ----------------------------------------------------------------------------
module frame_rate_meter_top #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [frm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [frm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [frm_pkg::FIELD_W-1:0]     timestamp_ms,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [frm_pkg::FIELD_W-1:0]     delta_ms,
	output logic [frm_pkg::FIELD_W-1:0]     avg_frame_ms,
	output logic [frm_pkg::FIELD_W-1:0]     frames_per_second,
	output logic [frm_pkg::FIELD_W-1:0]     elapsed_ms,
	output logic [frm_pkg::FIELD_W-1:0]     tick_number
);
	import frm_pkg::*;

	frm_cmd_t cmd;
	frm_sts_t sts;

	frm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	frm_dp #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.timestamp_ms      (timestamp_ms),
		.cmd               (cmd),
		.sts               (sts),
		.delta_ms          (delta_ms),
		.avg_frame_ms      (avg_frame_ms),
		.frames_per_second (frames_per_second),
		.elapsed_ms        (elapsed_ms),
		.tick_number       (tick_number)
	);

`ifndef SYNTHESIS
	// a taken beat is worked on before the next one is taken
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a beat is in progress");

	// every divider result is consumed by a window update
	a_div_used: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> cmd.write_avg || cmd.write_rate)
		else $error("divider result dropped");

	// a new result never overwrites one still pending
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !out_valid || out_ready)
		else $error("pending result overwritten");
`endif

endmodule
